@@ design/clle_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the
// character list editor with longest-run report. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clle_pkg;

  // List capacity and the widths that follow from it.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);

  // Beat widths, padded to whole bytes.
  localparam int IN_W  = 24;
  localparam int OUT_W = 24;

  // Item actions.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_REPORT = 2'd2;

  // Placement modes.
  localparam logic [1:0] WHERE_FRONT = 2'd0;
  localparam logic [1:0] WHERE_BACK  = 2'd1;
  localparam logic [1:0] WHERE_POS   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_LEN,
    PTR_AT,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_DN,
    RD_UP
  } rd_sel_e;

  typedef struct packed {
    logic    latch_item;
    logic    latch_status;
    ptr_op_e ptr_op;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_char;
    logic    len_inc;
    logic    len_dec;
    logic    rpt_clr;
    logic    step1;
    logic    step2;
    logic    fin1;
    logic    fin2;
    logic    push_stat;
    logic    push_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       is_report;
    logic       is_insert;
    logic       len_zero;
    logic [1:0] stat;
    logic       ptr_gt_at;
    logic       del_more;
    logic       ptr_lt_len;
    logic       out_free;
    logic       run_end_hit;
    logic       tail_hit;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ design/clle_dp.sv @@
// Datapath: item registers, character store, list length, run tracking and
// the output register. Depends on clle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clle_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [clle_pkg::IN_W-1:0] in_data_i,
  input  clle_pkg::ctrl_cmd_t       cmd_i,
  output clle_pkg::dp_sts_t         sts_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [clle_pkg::OUT_W-1:0] out_data_o,
  output logic                      out_last_o
);
  import clle_pkg::*;

  logic [1:0]       act_q, mode_q;
  logic [6:0]       pos_q;
  logic [7:0]       chr_q;
  logic [LEN_W-1:0] len_q, ptr_q, at_q, run_q, longest_q;
  logic [1:0]       stat_q;
  logic [7:0]       prev_q, pend_char_q, rdata_q;
  logic             pend_valid_q;
  logic [7:0]       store_q [CAPACITY];

  logic             out_valid_q, out_last_q, out_has_q;
  logic [1:0]       out_stat_q;
  logic [7:0]       out_char_q;
  logic [6:0]       out_len_q;

  logic [1:0]       stat;
  logic [LEN_W-1:0] at, ra, ptr_d;
  logic [7:0]       pos8, len8;
  logic             run_end, match, push, out_free;
  logic [LEN_W-1:0] run_new;

  // Status and target index of the held item.
  always_comb begin
    pos8 = {1'b0, pos_q};
    len8 = 8'(len_q);
    stat = ST_OK;
    at   = '0;
    case (act_q)
      ACT_INSERT: begin
        if (len_q >= LEN_W'(CAPACITY)) begin
          stat = ST_FULL;
        end else begin
          case (mode_q)
            WHERE_FRONT: at = '0;
            WHERE_BACK:  at = len_q;
            WHERE_POS: begin
              if (pos8 == 8'd0 || pos8 > len8 + 8'd1) stat = ST_RANGE;
              else at = LEN_W'(pos8 - 8'd1);
            end
            default: stat = ST_RANGE;
          endcase
        end
      end
      ACT_DELETE: begin
        case (mode_q)
          WHERE_FRONT: begin
            if (len_q == '0) stat = ST_RANGE;
            else at = '0;
          end
          WHERE_BACK: begin
            if (len_q == '0) stat = ST_RANGE;
            else at = len_q - 1'b1;
          end
          WHERE_POS: begin
            if (pos8 == 8'd0 || pos8 > len8) stat = ST_RANGE;
            else at = LEN_W'(pos8 - 8'd1);
          end
          default: stat = ST_RANGE;
        endcase
      end
      ACT_REPORT: stat = ST_OK;
      default:    stat = ST_RANGE;
    endcase
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_PTR:  ra = ptr_q;
      RD_DN:   ra = ptr_q - 1'b1;
      RD_UP:   ra = ptr_q + 1'b1;
      default: ra = ptr_q;
    endcase
  end

  always_comb begin
    case (cmd_i.ptr_op)
      PTR_LEN:  ptr_d = len_q;
      PTR_AT:   ptr_d = at;
      PTR_ZERO: ptr_d = '0;
      PTR_INC:  ptr_d = ptr_q + 1'b1;
      PTR_DEC:  ptr_d = ptr_q - 1'b1;
      default:  ptr_d = ptr_q;
    endcase
  end

  // Run tracking over the entry just read.
  assign run_end  = (ptr_q != '0) && (rdata_q != prev_q);
  assign run_new  = (ptr_q == '0 || run_end) ? LEN_W'(1) : run_q + 1'b1;
  assign match    = (cmd_i.step2 && run_end && run_q == longest_q) ||
                    (cmd_i.fin2 && run_q == longest_q);
  assign push     = cmd_i.push_stat || cmd_i.push_last || (match && pend_valid_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      store_q[ptr_q[IDX_W-1:0]] <= cmd_i.wr_char ? chr_q : rdata_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= store_q[ra[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      act_q  <= in_data_i[1:0];
      mode_q <= in_data_i[3:2];
      pos_q  <= in_data_i[10:4];
      chr_q  <= in_data_i[18:11];
    end
    if (cmd_i.latch_status) begin
      stat_q <= stat;
      at_q   <= at;
    end
    if (cmd_i.step1 || cmd_i.step2) begin
      prev_q <= rdata_q;
      run_q  <= run_new;
    end
    if (match) pend_char_q <= prev_q;
    if (push) begin
      if (cmd_i.push_stat) begin
        out_stat_q <= stat_q;
        out_has_q  <= 1'b0;
        out_char_q <= 8'd0;
        out_len_q  <= 7'd0;
        out_last_q <= 1'b1;
      end else begin
        out_stat_q <= ST_OK;
        out_has_q  <= 1'b1;
        out_char_q <= pend_char_q;
        out_len_q  <= 7'(longest_q);
        out_last_q <= cmd_i.push_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q        <= '0;
      ptr_q        <= '0;
      longest_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      if (cmd_i.len_inc) len_q <= len_q + 1'b1;
      else if (cmd_i.len_dec) len_q <= len_q - 1'b1;
      if (cmd_i.rpt_clr) begin
        longest_q <= '0;
      end else if (cmd_i.step1 && run_end && run_q > longest_q) begin
        longest_q <= run_q;
      end else if (cmd_i.fin1 && run_q > longest_q) begin
        longest_q <= run_q;
      end
      if (cmd_i.rpt_clr) pend_valid_q <= 1'b0;
      else if (match) pend_valid_q <= 1'b1;
      if (push) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o.is_report   = (act_q == ACT_REPORT);
    sts_o.is_insert   = (act_q == ACT_INSERT);
    sts_o.len_zero    = (len_q == '0);
    sts_o.stat        = stat;
    sts_o.ptr_gt_at   = (ptr_q > at_q);
    sts_o.del_more    = ({1'b0, ptr_q} + 1'b1) < {1'b0, len_q};
    sts_o.ptr_lt_len  = (ptr_q < len_q);
    sts_o.out_free    = out_free;
    sts_o.run_end_hit = run_end && (run_q == longest_q) && pend_valid_q;
    sts_o.tail_hit    = (run_q == longest_q) && pend_valid_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {6'd0, out_len_q, out_char_q, out_has_q, out_stat_q};
  assign out_last_o  = out_last_q;

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(CAPACITY))
    else $error("list length above capacity");

  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q == $past(len_q)) || (len_q == $past(len_q) + 1'b1) ||
    (len_q == $past(len_q) - 1'b1))
    else $error("list length moved by more than one");

  a_last_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_last |-> pend_valid_q)
    else $error("final report beat without a pending run");

endmodule

`default_nettype wire

@@ design/clle_ctrl.sv @@
// Controller state machine: sequences edits, shifts and the two report
// passes by commands to the datapath. Depends on clle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  clle_pkg::dp_sts_t   sts_i,
  output clle_pkg::ctrl_cmd_t cmd_o
);
  import clle_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_INS_RD  = 4'd2;
  localparam logic [3:0] S_INS_WR  = 4'd3;
  localparam logic [3:0] S_DEL_RD  = 4'd4;
  localparam logic [3:0] S_DEL_WR  = 4'd5;
  localparam logic [3:0] S_EMIT    = 4'd6;
  localparam logic [3:0] S_P1_RD   = 4'd7;
  localparam logic [3:0] S_P1_PR   = 4'd8;
  localparam logic [3:0] S_P1_FIN  = 4'd9;
  localparam logic [3:0] S_P2_RD   = 4'd10;
  localparam logic [3:0] S_P2_PR   = 4'd11;
  localparam logic [3:0] S_P2_FIN  = 4'd12;
  localparam logic [3:0] S_P2_LAST = 4'd13;

  logic [3:0] state_q, state_d;
  ctrl_cmd_t  cmd;

  always_comb begin
    cmd        = '0;
    cmd.ptr_op = PTR_HOLD;
    cmd.rd_sel = RD_PTR;
    state_d    = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.latch_item = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_report && !sts_i.len_zero) begin
          cmd.ptr_op  = PTR_ZERO;
          cmd.rpt_clr = 1'b1;
          state_d     = S_P1_RD;
        end else begin
          cmd.latch_status = 1'b1;
          if (sts_i.stat != ST_OK || sts_i.is_report) begin
            state_d = S_EMIT;
          end else if (sts_i.is_insert) begin
            cmd.ptr_op = PTR_LEN;
            state_d    = S_INS_RD;
          end else begin
            cmd.ptr_op = PTR_AT;
            state_d    = S_DEL_RD;
          end
        end
      end
      S_INS_RD: begin
        if (sts_i.ptr_gt_at) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_DN;
          state_d    = S_INS_WR;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_char = 1'b1;
          cmd.len_inc = 1'b1;
          state_d     = S_EMIT;
        end
      end
      S_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.ptr_op = PTR_DEC;
        state_d    = S_INS_RD;
      end
      S_DEL_RD: begin
        if (sts_i.del_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_UP;
          state_d    = S_DEL_WR;
        end else begin
          cmd.len_dec = 1'b1;
          state_d     = S_EMIT;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.ptr_op = PTR_INC;
        state_d    = S_DEL_RD;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd.push_stat = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_P1_RD: begin
        if (sts_i.ptr_lt_len) begin
          cmd.rd_en = 1'b1;
          state_d   = S_P1_PR;
        end else begin
          state_d = S_P1_FIN;
        end
      end
      S_P1_PR: begin
        cmd.step1  = 1'b1;
        cmd.ptr_op = PTR_INC;
        state_d    = S_P1_RD;
      end
      S_P1_FIN: begin
        cmd.fin1   = 1'b1;
        cmd.ptr_op = PTR_ZERO;
        state_d    = S_P2_RD;
      end
      S_P2_RD: begin
        if (sts_i.ptr_lt_len) begin
          cmd.rd_en = 1'b1;
          state_d   = S_P2_PR;
        end else begin
          state_d = S_P2_FIN;
        end
      end
      S_P2_PR: begin
        // A finished run that displaces a pending one needs the output free.
        if (!(sts_i.run_end_hit && !sts_i.out_free)) begin
          cmd.step2  = 1'b1;
          cmd.ptr_op = PTR_INC;
          state_d    = S_P2_RD;
        end
      end
      S_P2_FIN: begin
        if (!(sts_i.tail_hit && !sts_i.out_free)) begin
          cmd.fin2 = 1'b1;
          state_d  = S_P2_LAST;
        end
      end
      S_P2_LAST: begin
        if (sts_i.out_free) begin
          cmd.push_last = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd;

  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.rd_en && cmd.wr_en))
    else $error("store read and write in the same cycle");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.push_stat || cmd.push_last) |-> sts_i.out_free)
    else $error("result pushed into a full output register");

  a_run_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.step2 && sts_i.run_end_hit) |-> sts_i.out_free)
    else $error("run result pushed into a full output register");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.latch_item |=> (state_q == S_DECODE))
    else $error("accepted item not decoded next cycle");

endmodule

`default_nettype wire

@@ design/char_list_edit_longest_run_top.sv @@
// Top level of the character list editor with longest-run report.
// Instantiates clle_ctrl and clle_dp; depends on clle_pkg.
`timescale 1ns / 1ps
`default_nettype none

// This block keeps an ordered list of up to 64 character bytes. Each input
// beat is one command: insert a character at the front, the back or a
// 1-based position; delete the front, back or positioned entry; or report
// the longest run of equal adjacent characters. Every edit answers with a
// single beat carrying a status (ok, list full, position out of range),
// and a rejected edit leaves the list untouched. A report answers with one
// beat per run of maximal length in list order, tlast on the final one; an
// empty list reports one beat with has_char low and length zero. The block
// works on one command at a time. The character store is a single memory
// that does one access per cycle, so each entry moved takes a read and
// then a write. A report walks the store twice, reading each entry on
// both passes. Output stalls add cycles on top. A new command is taken
// as soon as the previous one is done, even while its last result beat
// still sits in the output register. No clearing pass follows reset.
module char_list_edit_longest_run_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: action[1:0], where_mode[3:2], position[10:4],
  // char_value[18:11], zero padding[23:19].
  input  logic [23:0] s_axis_tdata,
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: status[1:0], has_char[2], run_char[10:3],
  // longest_run[17:11], zero padding[23:18].
  output logic [23:0] m_axis_tdata,
  // Marks the final result beat of a command.
  output logic        m_axis_tlast
);
  import clle_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // The controller only sequences; all storage and arithmetic sit in the
  // datapath, and the two talk through the command and status structs.
  clle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath latches the beat when the controller accepts it and owns
  // the output register, so result beats drain independently of the work.
  clle_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire
